// ===== rtl/core/occd_pkg.sv =====
// Package with the shared types and constants of the ordinary cell descriptor check.
`default_nettype none
package occd_pkg;

    localparam int MAX_REFS          = 4;
    localparam int QUEUE_DEPTH_DEF   = 2;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HASHES  = 3'd1,
        ST_EXOTIC  = 3'd2,
        ST_REFS    = 3'd3,
        ST_BAD_REF = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_D2,
        PH_DATA,
        PH_REFS,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [7:0] cell_byte;
        logic       cell_start;
        logic [7:0] own_index;
        logic [7:0] total_cells;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [7:0]  cell_size;
        logic [7:0]  payload_bytes;
        logic [2:0]  ref_total;
        logic [2:0]  cell_level;
        logic [10:0] bit_length;
    } t_out;

    typedef struct packed {
        t_status    status;
        logic       full;
        logic [7:0] d1;
        logic [7:0] data_count;
        logic [6:0] last_pos;
        logic [2:0] last_tz;
        logic       any_nonzero;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/occd_in_if.sv =====
// Interface of the input byte channel.
`default_nettype none
interface occd_in_if
    import occd_pkg::*;
();
    logic valid;
    logic ready;
    t_in  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/occd_out_if.sv =====
// Interface of the result channel.
`default_nettype none
interface occd_out_if
    import occd_pkg::*;
();
    logic valid;
    logic ready;
    t_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ordinary_cell_descriptor_check_top.sv =====
// Ordinary cell descriptor check: top level with parser, record queue and formatter.
//
// The input channel i_in carries one byte of a serialized cell per transfer,
// with cell_start marking the first descriptor and the cell's index and the
// bag's cell count sampled on that byte. The output channel o_out carries one
// result per cell: status, cell size, data size, reference count, level and
// bit length. A result is sent at the end of a cell or at its first error;
// bytes after an error are dropped until the next cell start.
// The block takes one byte per cycle while the queue is not full. At the transfer
// of the byte that completes or fails the cell, the parser writes a record into
// the queue, and the formatter loads the output register from the queue head
// when that register is empty or its result is being taken by the receiver.
// When the receiver stalls, the output register holds its result and the
// queue keeps filling; input ready drops only when the queue of QUEUE_DEPTH
// records is full. Synchronous reset returns the parser to waiting for a cell
// start and empties the queue and the output register.
`default_nettype none
module ordinary_cell_descriptor_check_top
    import occd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    occd_in_if.sink    i_in,
    occd_out_if.source o_out
);

    logic    push;
    t_result push_data;
    logic    full;
    logic    pop;
    logic    nonempty;
    t_result head;

    occd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_full      (full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    occd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (full),
        .i_pop       (pop),
        .o_nonempty  (nonempty),
        .o_head      (head)
    );

    occd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

// ===== rtl/core/occd_front.sv =====
// Front part: byte parser that tracks the cell layout and queues result records.
`default_nettype none
module occd_front
    import occd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    occd_in_if.sink      i_in,
    input  wire logic    i_full,
    output logic         o_push,
    output t_result      o_push_data
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_d1, n_d1;
    logic [7:0] r_data_count, n_data_count;
    logic [7:0] r_bytes_seen, n_bytes_seen;
    logic [2:0] r_refs_left, n_refs_left;
    logic [6:0] r_last_pos, n_last_pos;
    logic [2:0] r_last_tz, n_last_tz;
    logic       r_any_nz, n_any_nz;
    logic [7:0] r_held_index, n_held_index;
    logic [7:0] r_held_count, n_held_count;

    logic       accept;
    logic [7:0] b;
    logic       start;
    logic [7:0] d2_count;
    logic       data_last;
    logic       ref_bad;
    logic [2:0] refs_dec;
    logic       flag_err;

    function automatic logic [2:0] trailing_zeros(input logic [7:0] v);
        logic [2:0] n;
        n = 3'd7;
        for (int i = 6; i >= 0; i--) begin
            if (v[i]) begin
                n = 3'(i);
            end
        end
        return n;
    endfunction

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.payload.cell_byte;
    assign start      = i_in.payload.cell_start;
    assign d2_count   = {1'b0, b[7:1]} + {7'd0, b[0]};
    assign data_last  = (r_bytes_seen + 8'd1) >= r_data_count;
    assign ref_bad    = !((b <= r_held_count) && (b > r_held_index));
    assign refs_dec   = r_refs_left - 3'd1;
    assign flag_err   = b[4] || b[3] || ({5'd0, b[2:0]} > 8'(MAX_REFS));

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            if (start) begin
                n_phase = flag_err ? PH_SKIP : PH_D2;
            end else begin
                case (r_phase)
                    PH_D2: begin
                        if (d2_count != 8'd0) begin
                            n_phase = PH_DATA;
                        end else if (r_refs_left != 3'd0) begin
                            n_phase = PH_REFS;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_DATA: begin
                        if (data_last) begin
                            n_phase = (r_refs_left != 3'd0) ? PH_REFS : PH_IDLE;
                        end
                    end
                    PH_REFS: begin
                        if (ref_bad) begin
                            n_phase = PH_SKIP;
                        end else if (refs_dec == 3'd0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    always_comb begin
        n_d1         = r_d1;
        n_data_count = r_data_count;
        n_bytes_seen = r_bytes_seen;
        n_refs_left  = r_refs_left;
        n_last_pos   = r_last_pos;
        n_last_tz    = r_last_tz;
        n_any_nz     = r_any_nz;
        n_held_index = r_held_index;
        n_held_count = r_held_count;
        if (accept) begin
            if (start) begin
                n_d1         = b;
                n_held_index = i_in.payload.own_index;
                n_held_count = i_in.payload.total_cells;
                n_data_count = 8'd0;
                n_bytes_seen = 8'd0;
                n_refs_left  = b[2:0];
                n_last_pos   = 7'd0;
                n_last_tz    = 3'd0;
                n_any_nz     = 1'b0;
            end else begin
                case (r_phase)
                    PH_D2: n_data_count = d2_count;
                    PH_DATA: begin
                        if (b != 8'd0) begin
                            n_any_nz   = 1'b1;
                            n_last_pos = r_bytes_seen[6:0];
                            n_last_tz  = trailing_zeros(b);
                        end
                        n_bytes_seen = r_bytes_seen + 8'd1;
                    end
                    PH_REFS: begin
                        if (!ref_bad) begin
                            n_refs_left = refs_dec;
                        end
                    end
                    default: n_d1 = r_d1;
                endcase
            end
        end
    end

    always_comb begin
        o_push                  = 1'b0;
        o_push_data.status      = ST_OK;
        o_push_data.full        = 1'b1;
        o_push_data.d1          = n_d1;
        o_push_data.data_count  = n_data_count;
        o_push_data.last_pos    = n_last_pos;
        o_push_data.last_tz     = n_last_tz;
        o_push_data.any_nonzero = n_any_nz;
        if (accept) begin
            if (start) begin
                o_push           = flag_err;
                o_push_data.full = 1'b0;
                if (b[4]) begin
                    o_push_data.status = ST_HASHES;
                end else if (b[3]) begin
                    o_push_data.status = ST_EXOTIC;
                end else begin
                    o_push_data.status = ST_REFS;
                end
            end else begin
                case (r_phase)
                    PH_D2:   o_push = (d2_count == 8'd0) && (r_refs_left == 3'd0);
                    PH_DATA: o_push = data_last && (r_refs_left == 3'd0);
                    PH_REFS: begin
                        o_push = ref_bad || (refs_dec == 3'd0);
                        if (ref_bad) begin
                            o_push_data.status = ST_BAD_REF;
                        end
                    end
                    default: o_push = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_d1         <= 8'd0;
            r_data_count <= 8'd0;
            r_bytes_seen <= 8'd0;
            r_refs_left  <= 3'd0;
            r_last_pos   <= 7'd0;
            r_last_tz    <= 3'd0;
            r_any_nz     <= 1'b0;
            r_held_index <= 8'd0;
            r_held_count <= 8'd0;
        end else begin
            r_phase      <= n_phase;
            r_d1         <= n_d1;
            r_data_count <= n_data_count;
            r_bytes_seen <= n_bytes_seen;
            r_refs_left  <= n_refs_left;
            r_last_pos   <= n_last_pos;
            r_last_tz    <= n_last_tz;
            r_any_nz     <= n_any_nz;
            r_held_index <= n_held_index;
            r_held_count <= n_held_count;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/occd_fifo.sv =====
// Short record queue between the parser and the result formatter.
`default_nettype none
module occd_fifo
    import occd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_push_data,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_nonempty,
    output t_result      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result        r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_count, n_count;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != CW'(0));
    assign o_head     = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? PW'(0) : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? PW'(0) : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/occd_back.sv =====
// Back part: turns queued records into result fields and holds the output register.
`default_nettype none
module occd_back
    import occd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_nonempty,
    input  wire t_result i_head,
    output logic         o_pop,
    occd_out_if.source   o_out
);

    logic        r_valid;
    t_out        r_out, n_out;
    logic [7:0]  pos_next;
    logic [10:0] len_full;

    assign o_pop       = i_nonempty && (!r_valid || o_out.ready);
    assign o_out.valid = r_valid;
    assign o_out.payload = r_out;
    assign pos_next    = {1'b0, i_head.last_pos} + 8'd1;

    always_comb begin
        if (!i_head.d1[0]) begin
            len_full = {i_head.data_count, 3'b000};
        end else if (!i_head.any_nonzero) begin
            len_full = 11'd0;
        end else begin
            len_full = {pos_next, 3'b000} - ({8'd0, i_head.last_tz} + 11'd1);
        end
    end

    always_comb begin
        n_out.status        = i_head.status;
        n_out.ref_total     = i_head.d1[2:0];
        n_out.cell_level    = i_head.d1[7:5];
        n_out.cell_size     = 8'd0;
        n_out.payload_bytes = 8'd0;
        n_out.bit_length    = 11'd0;
        if (i_head.full) begin
            n_out.cell_size     = 8'd2 + i_head.data_count + {5'd0, i_head.d1[2:0]};
            n_out.payload_bytes = i_head.data_count;
            n_out.bit_length    = len_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

// ===== sim/tb_ordinary_cell_descriptor_check_top.sv =====
// Self-checking testbench for the ordinary cell descriptor check, with its own cell parser model.
`timescale 1ns / 100ps
module tb_ordinary_cell_descriptor_check_top
    import occd_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    occd_in_if  in_if();
    occd_out_if out_if();

    ordinary_cell_descriptor_check_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Parser state of the model.
    t_phase     cur_phase = PH_IDLE;
    logic [7:0] cur_d1 = '0;
    logic [7:0] cur_len = '0;
    logic [7:0] cur_seen = '0;
    logic [2:0] cur_refs_left = '0;
    logic [7:0] cur_last_pos = '0;
    logic [2:0] cur_last_tz = '0;
    logic       cur_any_nz = 1'b0;
    logic [7:0] cur_own = '0;
    logic [7:0] cur_total = '0;

    t_out expected_results[$];
    t_out observed_result;
    t_out predicted_result;

    int error_count = 0;
    int bytes_sent = 0;
    int cells_started = 0;
    int results_checked = 0;
    int status_seen[0:7];
    int cycle_count = 0;
    int hold_request = 0;
    int hold_left = 0;
    bit no_idle = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [2:0] low_zeros(input logic [7:0] v);
        logic [2:0] n;
        n = 3'd0;
        while (n < 3'd7 && v[n] == 1'b0) n++;
        return n;
    endfunction

    function automatic t_out make_result(input t_status st, input bit full);
        t_out r;
        logic [10:0] bl;
        logic [10:0] pos_bits;
        logic [10:0] tz_bits;
        pos_bits = {3'b000, cur_last_pos};
        tz_bits = {8'd0, cur_last_tz};
        if (cur_d1[0] == 1'b0) begin
            bl = {cur_len, 3'b000};
        end else if (!cur_any_nz) begin
            bl = '0;
        end else begin
            bl = (pos_bits + 11'd1) * 11'd8 - tz_bits - 11'd1;
        end
        r.status        = st;
        r.cell_size     = full ? cur_len + {5'd0, cur_d1[2:0]} + 8'd2 : 8'd0;
        r.payload_bytes = full ? cur_len : 8'd0;
        r.ref_total     = cur_d1[2:0];
        r.cell_level    = cur_d1[7:5];
        r.bit_length    = full ? bl : 11'd0;
        return r;
    endfunction

    task automatic predict_byte(input t_in it);
        logic [7:0] b;
        b = it.cell_byte;
        if (it.cell_start) begin
            cur_d1 = b;
            cur_own = it.own_index;
            cur_total = it.total_cells;
            cur_len = '0;
            cur_seen = '0;
            cur_refs_left = b[2:0];
            cur_last_pos = '0;
            cur_last_tz = '0;
            cur_any_nz = 1'b0;
            if (b[4]) begin
                cur_phase = PH_SKIP;
                expected_results.push_back(make_result(ST_HASHES, 1'b0));
            end else if (b[3]) begin
                cur_phase = PH_SKIP;
                expected_results.push_back(make_result(ST_EXOTIC, 1'b0));
            end else if (b[2:0] > MAX_REFS) begin
                cur_phase = PH_SKIP;
                expected_results.push_back(make_result(ST_REFS, 1'b0));
            end else begin
                cur_phase = PH_D2;
            end
        end else begin
            case (cur_phase)
                PH_D2: begin
                    cur_len = {1'b0, b[7:1]} + {7'd0, b[0]};
                    if (cur_len != 0) begin
                        cur_phase = PH_DATA;
                    end else if (cur_refs_left != 0) begin
                        cur_phase = PH_REFS;
                    end else begin
                        cur_phase = PH_IDLE;
                        expected_results.push_back(make_result(ST_OK, 1'b1));
                    end
                end
                PH_DATA: begin
                    if (b != 0) begin
                        cur_any_nz = 1'b1;
                        cur_last_pos = cur_seen;
                        cur_last_tz = low_zeros(b);
                    end
                    cur_seen = cur_seen + 8'd1;
                    if (cur_seen >= cur_len) begin
                        if (cur_refs_left != 0) begin
                            cur_phase = PH_REFS;
                        end else begin
                            cur_phase = PH_IDLE;
                            expected_results.push_back(make_result(ST_OK, 1'b1));
                        end
                    end
                end
                PH_REFS: begin
                    if (!(b <= cur_total && b > cur_own)) begin
                        cur_phase = PH_SKIP;
                        expected_results.push_back(make_result(ST_BAD_REF, 1'b1));
                    end else begin
                        cur_refs_left = cur_refs_left - 3'd1;
                        if (cur_refs_left == 0) begin
                            cur_phase = PH_IDLE;
                            expected_results.push_back(make_result(ST_OK, 1'b1));
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    // Sender: returns at the rising edge on which the transfer took place.
    task automatic send_byte(input logic [7:0] value, input logic start,
                             input logic [7:0] own, input logic [7:0] total);
        t_in it;
        it.cell_byte = value;
        it.cell_start = start;
        it.own_index = own;
        it.total_cells = total;
        @(negedge i_clk);
        if (!no_idle && $urandom_range(99) < 19) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.payload <= it;
        do @(posedge i_clk); while (!in_if.ready);
        predict_byte(it);
        bytes_sent++;
        if (start) cells_started++;
    endtask

    task automatic send_next(input logic [7:0] value);
        logic [7:0] own;
        logic [7:0] total;
        own = 8'($urandom_range(255));
        total = 8'($urandom_range(255));
        send_byte(value, 1'b0, own, total);
    endtask

    task automatic release_input;
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic wait_for_results;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] good_descriptor();
        logic [2:0] lvl;
        logic [2:0] nrefs;
        lvl = 3'($urandom_range(7));
        nrefs = 3'($urandom_range(MAX_REFS));
        return {lvl, 2'b00, nrefs};
    endfunction

    // A whole cell with random content; references stay in range except at bad_pct.
    task automatic send_cell(input logic [7:0] d1, input logic [7:0] d2,
                             input int zero_pct, input int bad_pct);
        logic [7:0] own;
        logic [7:0] total;
        logic [7:0] v;
        int n_data;
        own = 8'($urandom_range(254));
        total = 8'($urandom_range(255, own + 1));
        n_data = int'(d2[7:1]) + int'(d2[0]);
        send_byte(d1, 1'b1, own, total);
        send_next(d2);
        for (int i = 0; i < n_data; i++) begin
            if ($urandom_range(99) < zero_pct) v = 8'h00;
            else if ($urandom_range(9) == 0) v = 8'h01 << $urandom_range(7);
            else v = 8'($urandom_range(255));
            send_next(v);
        end
        for (int i = 0; i < int'(d1[2:0]); i++) begin
            if ($urandom_range(99) < bad_pct) v = 8'($urandom_range(255));
            else v = 8'($urandom_range(total, own + 1));
            send_next(v);
        end
    endtask

    task automatic test_stray_bytes;
        send_next(8'h00);
        send_next(8'hFF);
        send_next(8'h5A);
    endtask

    task automatic test_flag_errors;
        send_byte(8'hFF, 1'b1, 8'd3, 8'd200);
        send_next(8'h01);
        send_byte(8'h18, 1'b1, 8'd0, 8'd0);
        send_byte(8'h08, 1'b1, 8'd1, 8'd2);
        send_byte(8'h0F, 1'b1, 8'd255, 8'd255);
        send_byte(8'h07, 1'b1, 8'd0, 8'd255);
        send_byte(8'hA5, 1'b1, 8'd0, 8'd255);
        send_byte(8'h06, 1'b1, 8'd7, 8'd9);
        send_next(8'hFF);
    endtask

    task automatic test_empty_cells;
        send_byte(8'h00, 1'b1, 8'd0, 8'd0);
        send_next(8'h00);
        send_byte(8'hE0, 1'b1, 8'd0, 8'd0);
        send_next(8'h01);
        send_next(8'h00);
        send_byte(8'h01, 1'b1, 8'd3, 8'd9);
        send_next(8'h00);
        send_next(8'd9);
        send_byte(8'h21, 1'b1, 8'd3, 8'd9);
        send_next(8'h02);
        send_next(8'h00);
        send_next(8'd4);
    endtask

    task automatic test_largest_cells;
        send_byte(8'h04, 1'b1, 8'd0, 8'd255);
        send_next(8'hFF);
        repeat (128) send_next(8'($urandom_range(255, 1)));
        send_next(8'd255);
        send_next(8'd1);
        send_next(8'd128);
        send_next(8'd200);
        send_byte(8'hE3, 1'b1, 8'd254, 8'd255);
        send_next(8'hFF);
        for (int i = 0; i < 128; i++) begin
            if (i < 100) send_next(8'($urandom_range(255)));
            else if (i == 100) send_next(8'h80);
            else send_next(8'h00);
        end
        repeat (3) send_next(8'd255);
    endtask

    task automatic test_bad_references;
        send_byte(8'h03, 1'b1, 8'd10, 8'd20);
        send_next(8'h00);
        send_next(8'd11);
        send_next(8'd20);
        send_next(8'd21);
        send_byte(8'h02, 1'b1, 8'd10, 8'd20);
        send_next(8'h02);
        send_next(8'h01);
        send_next(8'd10);
        send_byte(8'h01, 1'b1, 8'd255, 8'd255);
        send_next(8'h00);
        send_next(8'd255);
        send_byte(8'h01, 1'b1, 8'd200, 8'd100);
        send_next(8'h00);
        send_next(8'd150);
        send_byte(8'h01, 1'b1, 8'd0, 8'd0);
        send_next(8'h00);
        send_next(8'd0);
    endtask

    task automatic test_mid_cell_start;
        send_byte(8'h02, 1'b1, 8'd5, 8'd9);
        send_next(8'h06);
        send_next(8'h11);
        send_byte(8'h00, 1'b1, 8'd0, 8'd0);
        send_next(8'h00);
        send_byte(8'h03, 1'b1, 8'd5, 8'd9);
        send_next(8'h00);
        send_next(8'd7);
        send_byte(8'h41, 1'b1, 8'd1, 8'd2);
        send_next(8'h02);
        send_next(8'h0C);
        send_next(8'd2);
    endtask

    // The receiver stops for a long stretch while short cells keep coming.
    task automatic test_backpressure;
        release_input;
        wait_for_results;
        hold_request = 150;
        no_idle = 1'b1;
        repeat (15) begin
            send_byte(8'h00, 1'b1, 8'd0, 8'd0);
            send_next(8'h00);
            send_byte(8'hE0, 1'b1, 8'd0, 8'd0);
            send_next(8'h01);
        end
        no_idle = 1'b0;
        release_input;
        wait_for_results;
    endtask

    task automatic test_sender_pause;
        repeat (5) send_cell(good_descriptor(), 8'($urandom_range(12)), 30, 5);
        release_input;
        wait_for_results;
        repeat (5) send_cell(good_descriptor(), 8'($urandom_range(12)), 30, 5);
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int stop_at;
        int kind;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] own;
        logic [7:0] total;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(99);
            own = 8'($urandom_range(255));
            total = 8'($urandom_range(255));
            if (kind < 78) begin
                d2 = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(24));
                send_cell(good_descriptor(), d2, 30, 5);
            end else if (kind < 88) begin
                d1 = 8'($urandom_range(255));
                case ($urandom_range(2))
                    0: d1[4] = 1'b1;
                    1: begin
                        d1[4] = 1'b0;
                        d1[3] = 1'b1;
                    end
                    default: begin
                        d1[4:3] = 2'b00;
                        d1[2:0] = 3'($urandom_range(7, MAX_REFS + 1));
                    end
                endcase
                send_byte(d1, 1'b1, own, total);
                repeat ($urandom_range(3)) send_next(8'($urandom_range(255)));
            end else if (kind < 94) begin
                send_byte(good_descriptor(), 1'b1, own, total);
                send_next(8'd40);
                repeat ($urandom_range(10)) send_next(8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(4, 1)) send_next(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic test_steady_stream;
        no_idle = 1'b1;
        test_random_traffic(100);
        no_idle = 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (!no_idle && $urandom_range(99) < 19) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            observed_result = out_if.payload;
            if (expected_results.size() == 0) begin
                $display("%0t: result with no expectation: expected none, actual status %0d",
                         $time, observed_result.status);
                error_count++;
            end else begin
                predicted_result = expected_results.pop_front();
                check_field("status", predicted_result.status, observed_result.status);
                check_field("cell_size", predicted_result.cell_size, observed_result.cell_size);
                check_field("payload_bytes", predicted_result.payload_bytes,
                            observed_result.payload_bytes);
                check_field("ref_total", predicted_result.ref_total, observed_result.ref_total);
                check_field("cell_level", predicted_result.cell_level,
                            observed_result.cell_level);
                check_field("bit_length", predicted_result.bit_length,
                            observed_result.bit_length);
                results_checked++;
                status_seen[predicted_result.status]++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 8; i++) status_seen[i] = 0;
        in_if.valid = 1'b0;
        in_if.payload = '0;
        out_if.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_stray_bytes;
        test_flag_errors;
        test_empty_cells;
        test_largest_cells;
        test_bad_references;
        test_mid_cell_start;
        test_backpressure;
        test_sender_pause;
        test_steady_stream;
        test_random_traffic(100);
        release_input;
        wait_for_results;
        repeat (8) @(posedge i_clk);

        $display("Checked %0d cell results from %0d byte transfers in %0d started cells.",
                 results_checked, bytes_sent, cells_started);
        $display("Statuses: ok %0d, hashes %0d, exotic %0d, too many refs %0d, bad ref %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/occd_pkg.sv
rtl/core/occd_in_if.sv
rtl/core/occd_out_if.sv
rtl/core/occd_front.sv
rtl/core/occd_fifo.sv
rtl/core/occd_back.sv
rtl/core/ordinary_cell_descriptor_check_top.sv
sim/tb_ordinary_cell_descriptor_check_top.sv
